// ===== rtl/wfr_pkg.sv =====
package wfr_pkg;

    localparam logic [7:0]  SOF_BYTE   = 8'hAA;
    localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_TOPBIT = 32'h8000_0000;

    typedef struct packed {
        logic        frame_start;
        logic        frame_finish;
        logic        byte_valid;
        logic [7:0]  payload_byte;
        logic [31:0] timestamp;
        logic [7:0]  frame_type;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } result_t;

    typedef enum logic [3:0] {
        STEP_SOF,
        STEP_TS0,
        STEP_TS1,
        STEP_TS2,
        STEP_TS3,
        STEP_TYPE,
        STEP_PAYLOAD,
        STEP_CRC0,
        STEP_CRC1,
        STEP_CRC2,
        STEP_CRC3
    } step_t;

    // Control from the sequencer to the CRC unit for the byte emitted this cycle.
    typedef struct packed {
        logic       emit;
        logic       reload;
        logic       absorb;
        logic       fold_pad;
        logic       reinit;
        logic [7:0] data;
    } crc_ctrl_t;

    // Column i holds the CRC of a word with only bit i set after 32 MSB-first shifts.
    function automatic logic [31:0][31:0] crc_fold_columns();
        logic [31:0][31:0] cols;
        logic [31:0]       v;
        for (int i = 0; i < 32; i++)
        begin
            v = 32'h1 << i;
            for (int k = 0; k < 32; k++)
            begin
                if ((v & CRC_TOPBIT) != 32'h0)
                begin
                    v = (v << 1) ^ CRC_POLY;
                end
                else
                begin
                    v = v << 1;
                end
            end
            cols[i] = v;
        end
        return cols;
    endfunction

    localparam logic [31:0][31:0] CRC_COLS = crc_fold_columns();

    // The fold is linear: XOR the columns of the set bits.
    function automatic logic [31:0] crc_fold(input logic [31:0] x);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                r = r ^ CRC_COLS[i];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/wfr_crc.sv =====
module wfr_crc
    import wfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_ctrl_t   ctrl,
    output logic [31:0] crc_word
);

    logic [31:0] crc_reg, crc_next;
    logic [23:0] word_reg, word_next;
    logic [1:0]  lane_reg, lane_next;

    logic [31:0] crc_base;
    logic [23:0] word_base;
    logic [1:0]  lane_base;
    logic [31:0] pad_word;
    logic [31:0] fold_res;
    logic [31:0] crc_pad;

    always_comb
    begin
        crc_base  = ctrl.reload ? CRC_INIT : crc_reg;
        word_base = ctrl.reload ? 24'h0 : word_reg;
        lane_base = ctrl.reload ? 2'd0 : lane_reg;

        case (lane_base)
            2'd1:    pad_word = {24'hFF_FFFF, word_base[7:0]};
            2'd2:    pad_word = {16'hFFFF, word_base[15:0]};
            2'd3:    pad_word = {8'hFF, word_base};
            default: pad_word = {8'h00, word_base};
        endcase

        fold_res = crc_fold(crc_base ^ (ctrl.absorb ? {ctrl.data, word_base} : pad_word));
        crc_pad  = (lane_base != 2'd0) ? fold_res : crc_base;
        crc_word = ctrl.fold_pad ? crc_pad : crc_reg;

        crc_next  = crc_reg;
        word_next = word_reg;
        lane_next = lane_reg;
        if (ctrl.emit)
        begin
            if (ctrl.absorb)
            begin
                crc_next  = crc_base;
                word_next = word_base;
                lane_next = lane_base + 2'd1;
                case (lane_base)
                    2'd0:    word_next[7:0]   = ctrl.data;
                    2'd1:    word_next[15:8]  = ctrl.data;
                    2'd2:    word_next[23:16] = ctrl.data;
                    default:
                    begin
                        crc_next  = fold_res;
                        word_next = 24'h0;
                    end
                endcase
            end
            if (ctrl.fold_pad)
            begin
                crc_next  = crc_pad;
                word_next = 24'h0;
                lane_next = 2'd0;
            end
            if (ctrl.reinit)
            begin
                crc_next = CRC_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            word_reg <= 24'h0;
            lane_reg <= 2'd0;
        end
        else
        begin
            crc_reg  <= crc_next;
            word_reg <= word_next;
            lane_reg <= lane_next;
        end
    end

`ifndef SYNTHESIS
    a_pad_clears_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && ctrl.fold_pad) |=> (lane_reg == 2'd0 && word_reg == 24'h0))
        else $error("partial word not cleared after pad fold");
    a_reinit_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && ctrl.reinit) |=> (crc_reg == CRC_INIT))
        else $error("crc not reloaded at frame end");
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.emit |=> ($stable(crc_reg) && $stable(word_reg) && $stable(lane_reg)))
        else $error("crc state moved without an emitted byte");
`endif

endmodule

// ===== rtl/wfr_seq.sv =====
module wfr_seq
    import wfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    input  logic        out_free,
    input  logic [31:0] crc_word,
    output crc_ctrl_t   ctrl,
    output logic        emit,
    output result_t     res_next
);

    item_t hold_reg;
    logic  hold_valid_reg, hold_valid_next;
    step_t step_reg, step_next;
    step_t first_step;
    step_t after_step;
    logic  last;
    logic  load;
    logic  has_work;
    logic [7:0] data_byte;
    logic [7:0] cur_byte;

    always_comb
    begin
        has_work = item.frame_start | item.byte_valid | item.frame_finish;
        if (item.frame_start)
        begin
            first_step = STEP_SOF;
        end
        else if (item.byte_valid)
        begin
            first_step = STEP_PAYLOAD;
        end
        else
        begin
            first_step = STEP_CRC0;
        end

        // Pick the step after the current one; last marks the item's final byte.
        last       = 1'b0;
        after_step = step_reg;
        unique case (step_reg)
            STEP_SOF:     after_step = STEP_TS0;
            STEP_TS0:     after_step = STEP_TS1;
            STEP_TS1:     after_step = STEP_TS2;
            STEP_TS2:     after_step = STEP_TS3;
            STEP_TS3:     after_step = STEP_TYPE;
            STEP_TYPE:
            begin
                if (hold_reg.byte_valid)
                begin
                    after_step = STEP_PAYLOAD;
                end
                else if (hold_reg.frame_finish)
                begin
                    after_step = STEP_CRC0;
                end
                else
                begin
                    last = 1'b1;
                end
            end
            STEP_PAYLOAD:
            begin
                if (hold_reg.frame_finish)
                begin
                    after_step = STEP_CRC0;
                end
                else
                begin
                    last = 1'b1;
                end
            end
            STEP_CRC0:    after_step = STEP_CRC1;
            STEP_CRC1:    after_step = STEP_CRC2;
            STEP_CRC2:    after_step = STEP_CRC3;
            STEP_CRC3:    last = 1'b1;
            default:      last = 1'b1;
        endcase

        // Bytes fed to the CRC come from the held request only.
        case (step_reg)
            STEP_SOF:     data_byte = SOF_BYTE;
            STEP_TS0:     data_byte = hold_reg.timestamp[7:0];
            STEP_TS1:     data_byte = hold_reg.timestamp[15:8];
            STEP_TS2:     data_byte = hold_reg.timestamp[23:16];
            STEP_TS3:     data_byte = hold_reg.timestamp[31:24];
            STEP_TYPE:    data_byte = hold_reg.frame_type;
            STEP_PAYLOAD: data_byte = hold_reg.payload_byte;
            default:      data_byte = 8'h00;
        endcase

        case (step_reg)
            STEP_CRC0:    cur_byte = crc_word[7:0];
            STEP_CRC1:    cur_byte = crc_word[15:8];
            STEP_CRC2:    cur_byte = crc_word[23:16];
            STEP_CRC3:    cur_byte = crc_word[31:24];
            default:      cur_byte = data_byte;
        endcase

        emit       = hold_valid_reg & out_free;
        item_ready = !hold_valid_reg | (emit & last);
        load       = item_valid & item_ready & has_work;

        hold_valid_next = hold_valid_reg;
        step_next       = step_reg;
        if (load)
        begin
            hold_valid_next = 1'b1;
            step_next       = first_step;
        end
        else if (emit)
        begin
            hold_valid_next = !last;
            step_next       = after_step;
        end

        ctrl.emit     = emit;
        ctrl.reload   = (step_reg == STEP_SOF);
        ctrl.absorb   = (step_reg <= STEP_PAYLOAD);
        ctrl.fold_pad = (step_reg == STEP_CRC0);
        ctrl.reinit   = (step_reg == STEP_CRC3);
        ctrl.data     = data_byte;

        res_next.out_byte  = cur_byte;
        res_next.run_last  = last;
        res_next.frame_end = (step_reg == STEP_CRC3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            step_reg       <= STEP_SOF;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            step_reg       <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= item;
        end
    end

`ifndef SYNTHESIS
    a_stall_holds_step: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !emit) |=> (hold_valid_reg && $stable(step_reg)))
        else $error("step moved while output stalled");
    a_crc_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && step_reg == STEP_CRC3) |-> last)
        else $error("final crc byte not marked last");
    a_mid_item_keeps_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !last) |=> hold_valid_reg)
        else $error("item dropped before its last byte");
`endif

endmodule

// ===== rtl/wfr_out.sv =====
module wfr_out
    import wfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    emit,
    input  result_t res_next,
    output logic    out_free,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    logic    res_valid_reg, res_valid_next;
    result_t res_reg;

    always_comb
    begin
        out_free       = !res_valid_reg | res_ready;
        res_valid_next = emit | (res_valid_reg & !res_ready);
        res_valid      = res_valid_reg;
        res            = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/crc32_word_framer.sv =====
// Byte framer with a word-fed CRC-32 (poly 04C11DB7, init all ones, no final xor).
// Request channel: item_valid / item_ready / item. Each request carries flags
// frame_start, byte_valid and frame_finish plus a payload byte, timestamp and type.
// Result channel: res_valid / res_ready / res, one framed byte per result.
// A request expands to up to 11 bytes: start byte 0xAA, timestamp LE and type on
// frame_start; the payload byte on byte_valid; the CRC LE on frame_finish.
// A request is first registered in the hold register; its first byte is then
// emitted into the result register. The sequencer emits one byte per cycle while
// the result register is free; a plain payload byte gives 1 byte, a frame with
// header and CRC up to 11. The next request is taken in the cycle the current
// one's last byte is emitted, so payload bytes stream at one per cycle while the
// receiver keeps up. A request with no flag set is accepted and produces nothing.
// Reset clears the hold and result valid flags and loads the CRC with all ones.
// When the receiver stalls, the result register holds its byte, the sequencer
// holds its step, and item_ready stays low while a request is held.
module crc32_word_framer
    import wfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    crc_ctrl_t   ctrl;
    logic [31:0] crc_word;
    logic        emit;
    logic        out_free;
    result_t     res_next;

    // Hold the request and walk its bytes.
    wfr_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .out_free   (out_free),
        .crc_word   (crc_word),
        .ctrl       (ctrl),
        .emit       (emit),
        .res_next   (res_next)
    );

    // Pack bytes into words, fold each full word into the CRC and pad a partial word at finish.
    wfr_crc u_crc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .crc_word (crc_word)
    );

    // Result register parts the sequencer from the receiver.
    wfr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .res_next  (res_next),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// ===== bench/crc32_word_framer_test.sv =====
`timescale 1ns / 1ps

module crc32_word_framer_test;
    import wfr_pkg::*;

    localparam int PREDICT          = -1;   // row carries no typed bytes
    localparam int RANDOM_REQUESTS  = 150;
    localparam int MID_PAUSE_AT     = 100;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES     = 30;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

    // One directed request. Where n_typed is not PREDICT, the expected bytes are
    // listed first-byte-leftmost in typed; run_last falls on the last of them.
    typedef struct {
        item_t           req;
        int              n_typed;
        logic [0:6][7:0] typed;
    } dir_row_t;

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item       = '0;
    logic    res_valid;
    logic    res_ready  = 1'b0;
    result_t res;

    // Predictor state: running CRC, partial word and its fill count.
    logic [31:0] crc_acc  = CRC_INIT;
    logic [23:0] word_acc = '0;
    logic [1:0]  lane_cnt = '0;

    result_t pending_bytes[$];
    int      fail_count    = 0;
    int      sent_count    = 0;
    int      burst_left    = 0;
    logic    long_hold_req = 1'b0;

    crc32_word_framer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic item_t req_of(input logic s, input logic f, input logic v,
                                     input logic [7:0] b, input logic [31:0] ts,
                                     input logic [7:0] ty);
        item_t r;
        r.frame_start  = s;
        r.frame_finish = f;
        r.byte_valid   = v;
        r.payload_byte = b;
        r.timestamp    = ts;
        r.frame_type   = ty;
        return r;
    endfunction

    function automatic item_t rand_req(input logic s, input logic f, input logic v);
        return req_of(s, f, v, 8'($urandom), $urandom, 8'($urandom));
    endfunction

    // Directed sequence: lanes 1..3 and aligned at finish, abandoned frame,
    // empty frame, finish with and without start, idle requests in and out of frame.
    dir_row_t dir_tbl [22] = '{
        '{req_of(1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000, 8'h00), 0, '0},
        '{req_of(1'b0, 1'b0, 1'b1, 8'h00, 32'h0000_0000, 8'h00), 1, 56'h00_00_00_00_00_00_00},
        '{req_of(1'b0, 1'b0, 1'b1, 8'hFF, 32'h0000_0000, 8'h00), 1, 56'hFF_00_00_00_00_00_00},
        '{req_of(1'b0, 1'b1, 1'b0, 8'h00, 32'h0000_0000, 8'h00), PREDICT, '0},
        '{req_of(1'b1, 1'b0, 1'b0, 8'h00, 32'h0000_0000, 8'h00), 6, 56'hAA_00_00_00_00_00_00},
        '{req_of(1'b0, 1'b0, 1'b1, 8'h5A, 32'h0000_0000, 8'h00), 1, 56'h5A_00_00_00_00_00_00},
        '{req_of(1'b1, 1'b0, 1'b1, 8'hFF, 32'hFFFF_FFFF, 8'hFF), 7, 56'hAA_FF_FF_FF_FF_FF_FF},
        '{req_of(1'b0, 1'b1, 1'b1, 8'h00, 32'h0000_0000, 8'h00), PREDICT, '0},
        '{req_of(1'b1, 1'b1, 1'b0, 8'h00, 32'h1234_5678, 8'h01), PREDICT, '0},
        '{req_of(1'b1, 1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF, 8'hFF), PREDICT, '0},
        '{req_of(1'b1, 1'b1, 1'b1, 8'h00, 32'h0000_0000, 8'h00), PREDICT, '0},
        '{req_of(1'b0, 1'b0, 1'b1, 8'h11, 32'h0000_0000, 8'h00), 1, 56'h11_00_00_00_00_00_00},
        '{req_of(1'b0, 1'b0, 1'b1, 8'h22, 32'h0000_0000, 8'h00), 1, 56'h22_00_00_00_00_00_00},
        '{req_of(1'b0, 1'b1, 1'b1, 8'h33, 32'h0000_0000, 8'h00), PREDICT, '0},
        '{req_of(1'b1, 1'b0, 1'b0, 8'h00, 32'h8000_0001, 8'h80), 6, 56'hAA_01_00_00_80_80_00},
        '{req_of(1'b0, 1'b0, 1'b0, 8'hFF, 32'hFFFF_FFFF, 8'hFF), 0, '0},
        '{req_of(1'b0, 1'b0, 1'b1, 8'h01, 32'h0000_0000, 8'h00), 1, 56'h01_00_00_00_00_00_00},
        '{req_of(1'b0, 1'b0, 1'b1, 8'h80, 32'h0000_0000, 8'h00), 1, 56'h80_00_00_00_00_00_00},
        '{req_of(1'b0, 1'b1, 1'b1, 8'h7F, 32'h0000_0000, 8'h00), PREDICT, '0},
        '{req_of(1'b0, 1'b1, 1'b0, 8'h00, 32'h0000_0000, 8'h00), PREDICT, '0},
        '{req_of(1'b1, 1'b0, 1'b1, 8'hC3, 32'hA5A5_A5A5, 8'h5A), 7, 56'hAA_A5_A5_A5_A5_5A_C3},
        '{req_of(1'b0, 1'b1, 1'b0, 8'h00, 32'h0000_0000, 8'h00), PREDICT, '0}
    };

    // Shift one 32-bit word through the CRC, MSB first.
    function automatic logic [31:0] crc_shift32(input logic [31:0] crc, input logic [31:0] w);
        logic [31:0] c;
        c = crc ^ w;
        for (int k = 0; k < 32; k++)
        begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic absorb_byte(input logic [7:0] b);
        if (lane_cnt == 2'd3)
        begin
            crc_acc  = crc_shift32(crc_acc, {b, word_acc});
            word_acc = '0;
            lane_cnt = 2'd0;
        end
        else
        begin
            word_acc[8 * lane_cnt +: 8] = b;
            lane_cnt = lane_cnt + 2'd1;
        end
    endtask

    // Advance the predictor by one request; queue its bytes when keep is set.
    task automatic predict_request(input item_t req, input logic keep);
        logic [47:0] hdr;
        result_t     r;
        result_t     out_q[$];
        hdr = {req.frame_type, req.timestamp, SOF_BYTE};
        r   = '0;
        if (req.frame_start)
        begin
            crc_acc  = CRC_INIT;
            word_acc = '0;
            lane_cnt = '0;
            for (int i = 0; i < 6; i++)
            begin
                absorb_byte(hdr[8 * i +: 8]);
                r.out_byte = hdr[8 * i +: 8];
                out_q.push_back(r);
            end
        end
        if (req.byte_valid)
        begin
            absorb_byte(req.payload_byte);
            r.out_byte = req.payload_byte;
            out_q.push_back(r);
        end
        if (req.frame_finish)
        begin
            // Pad a partial word with ones; an aligned finish folds nothing.
            if (lane_cnt != 2'd0)
            begin
                crc_acc = crc_shift32(crc_acc,
                                      {8'h00, word_acc} | (CRC_INIT << {lane_cnt, 3'b000}));
            end
            for (int i = 0; i < 4; i++)
            begin
                r.out_byte  = crc_acc[8 * i +: 8];
                r.frame_end = (i == 3);
                out_q.push_back(r);
            end
            crc_acc  = CRC_INIT;
            word_acc = '0;
            lane_cnt = '0;
        end
        if (out_q.size() != 0)
        begin
            out_q[out_q.size() - 1].run_last = 1'b1;
        end
        if (keep)
        begin
            foreach (out_q[j])
            begin
                pending_bytes.push_back(out_q[j]);
            end
        end
    endtask

    // Offer a request in bursts with random gaps; return at the accepting edge.
    task automatic send_request(input item_t req);
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= req;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic issue(input item_t req);
        send_request(req);
        predict_request(req, 1'b1);
        if (req.frame_start || req.frame_finish || req.byte_valid)
        begin
            sent_count++;
        end
    endtask

    // Drop valid and hold until every expected byte has come out.
    task automatic drain_results();
        item_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_bytes.size() != 0);
    endtask

    // Compare every accepted byte with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected result: out_byte %h run_last %b frame_end %b",
                       res.out_byte, res.run_last, res.frame_end);
                fail_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (res.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, res.out_byte);
                    fail_count++;
                end
                if (res.run_last !== want.run_last)
                begin
                    $error("run_last: expected %b, got %b", want.run_last, res.run_last);
                    fail_count++;
                end
                if (res.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %b, got %b", want.frame_end, res.frame_end);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: segments of open, coin-flip and sparse readiness, plus one long hold.
    initial
    begin : rx_side
        rx_mode_t mode;
        int       seg_left;
        int       cyc;
        bit       hold_done;
        mode      = RX_OPEN;
        seg_left  = 0;
        cyc       = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (long_hold_req && !hold_done)
            begin
                res_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                res_ready <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = rx_mode_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(8, 40);
                end
                seg_left--;
                case (mode)
                    RX_OPEN:   res_ready <= 1'b1;
                    RX_COIN:   res_ready <= 1'($urandom_range(0, 1));
                    default:   res_ready <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stim
        int      kind;
        int      n_mid;
        bit      mid_pause_done;
        result_t typed_r;
        mid_pause_done = 1'b0;
        typed_r        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[i])
        begin
            send_request(dir_tbl[i].req);
            predict_request(dir_tbl[i].req, dir_tbl[i].n_typed == PREDICT);
            for (int j = 0; j < dir_tbl[i].n_typed; j++)
            begin
                typed_r.out_byte  = dir_tbl[i].typed[j];
                typed_r.run_last  = (j == dir_tbl[i].n_typed - 1);
                typed_r.frame_end = 1'b0;
                pending_bytes.push_back(typed_r);
            end
        end
        drain_results();

        // Hold the receiver off while requests keep coming, so the block backs up.
        long_hold_req <= 1'b1;

        while (sent_count < RANDOM_REQUESTS)
        begin
            if (!mid_pause_done && sent_count >= MID_PAUSE_AT)
            begin
                drain_results();
                mid_pause_done = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    issue(rand_req(1'b1, 1'b1, 1'($urandom_range(0, 1))));
                end
                else
                begin
                    issue(rand_req(1'b1, 1'b0, $urandom_range(0, 3) != 0));
                    n_mid = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20)
                                                        : $urandom_range(0, 6);
                    repeat (n_mid)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            issue(rand_req(1'b0, 1'b0, 1'b0));
                        end
                        issue(rand_req(1'b0, 1'b0, 1'b1));
                    end
                    issue(rand_req(1'b0, 1'b1, 1'($urandom_range(0, 1))));
                end
            end
            else if (kind == 7)
            begin
                issue(rand_req(1'b0, 1'b0, 1'b0));
            end
            else if (kind == 8)
            begin
                // payload or finish outside any started frame
                issue(rand_req(1'b0, 1'($urandom_range(0, 1)), 1'b1));
            end
            else
            begin
                // start left open; the next start abandons it
                issue(rand_req(1'b1, 1'b0, 1'($urandom_range(0, 1))));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wfr_pkg.sv
rtl/wfr_crc.sv
rtl/wfr_seq.sv
rtl/wfr_out.sv
rtl/crc32_word_framer.sv
bench/crc32_word_framer_test.sv
